/* design/grid_ray_caster_dda_unit_assert.svh */
// ----------------------------------------------------------------------------
// Grid ray caster assertion macros
// Shared forms for concurrent checks clocked on aclk, off during reset.
// ----------------------------------------------------------------------------
`ifndef GRID_RAY_CASTER_DDA_UNIT_ASSERT_SVH
`define GRID_RAY_CASTER_DDA_UNIT_ASSERT_SVH

// same-cycle implication
`define GRCD_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("grcd check failed");

// next-cycle implication
`define GRCD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("grcd check failed");

`endif

/* design/grcd_pkg.sv */
// ----------------------------------------------------------------------------
// Grid ray caster package
// Field widths, fixed-point constants, codes and the sequencer state type.
// ----------------------------------------------------------------------------
package grcd_pkg;

    localparam int MAP_SIDE_DEF = 64;
    localparam int FRAC_BITS    = 16;

    localparam int POS_W   = 22;
    localparam int DIR_W   = 18;
    localparam int SW_W    = 12;
    localparam int COL_W   = 12;
    localparam int CELL_W  = 6;
    localparam int DIST_W  = 24;
    localparam int RAY_W   = 32;
    localparam int CAM_W   = 30;
    localparam int MA_W    = 34;
    localparam int MB_W    = 30;
    localparam int PROD_W  = 64;
    localparam int DLT_W   = 39;
    localparam int SIDE_W  = 48;
    localparam int FRAC1_W = FRAC_BITS + 1;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 22;

    localparam logic [CFG_IDX_W-1:0] CFG_POS_X   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POS_Y   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DIR_X   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DIR_Y   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PLANE_X = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PLANE_Y = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN  = 3'd6;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_CAST  = 1'b1;

    localparam logic [DIST_W-1:0] DIST_MAX  = 24'hFF_FFFF;
    localparam logic [POS_W-1:0]  COORD_MAX = 22'h3F_FFFF;
    localparam logic [PROD_W-1:0] DELTA_INF = 64'd1 << 38;

    localparam logic signed [DIR_W-1:0] DIR_X_RST   = 18'sd65536;
    localparam logic signed [DIR_W-1:0] DIR_Y_RST   = 18'sd0;
    localparam logic signed [DIR_W-1:0] PLANE_X_RST = 18'sd0;
    localparam logic signed [DIR_W-1:0] PLANE_Y_RST = 18'sd43254;
    localparam logic [SW_W-1:0]         SCREEN_RST  = 12'd640;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CAM,
        ST_MUL_RX,
        ST_MUL_RY,
        ST_RY_CAP,
        ST_DIV_DX,
        ST_DIV_DY,
        ST_SX_MUL,
        ST_SY_MUL,
        ST_SY_CAP,
        ST_STEP,
        ST_CHECK,
        ST_DIST,
        ST_COORD_MUL,
        ST_COORD,
        ST_DONE
    } st_t;

endpackage

/* design/grcd_div.sv */
// ----------------------------------------------------------------------------
// Grid ray caster divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module grcd_div #(
    parameter int DVW = 39,
    parameter int DSW = 31
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           start,
    input  logic [DVW-1:0] dividend,
    input  logic [DSW-1:0] divisor,
    output logic           done,
    output logic [DVW-1:0] quotient
);
    localparam int CNTW = $clog2(DVW + 1);

    logic            busy_reg;
    logic            done_reg;
    logic [CNTW-1:0] cnt_reg;
    logic [DSW-1:0]  rem_reg;
    logic [DVW-1:0]  quo_reg;
    logic [DSW-1:0]  dvsr_reg;
    logic [DSW:0]    trial;
    logic [DSW:0]    diff;
    logic            fits;

    assign trial = {rem_reg, quo_reg[DVW-1]};
    assign fits  = trial >= {1'b0, dvsr_reg};
    assign diff  = trial - {1'b0, dvsr_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + CNTW'(1);
            if (cnt_reg == CNTW'(DVW - 1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end else begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg  <= '0;
            quo_reg  <= dividend;
            dvsr_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= fits ? diff[DSW-1:0] : trial[DSW-1:0];
            quo_reg <= {quo_reg[DVW-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

/* design/grcd_map.sv */
// ----------------------------------------------------------------------------
// Grid ray caster map store
// One-bit wall memory, registered read, swept to open after reset.
// ----------------------------------------------------------------------------
module grcd_map #(
    parameter int MAP_SIDE = 64
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 wr_en,
    input  logic [$clog2(MAP_SIDE*MAP_SIDE)-1:0] wr_addr,
    input  logic                                 wr_data,
    input  logic [$clog2(MAP_SIDE*MAP_SIDE)-1:0] rd_addr,
    output logic                                 rd_data,
    output logic                                 busy
);
    localparam int DEPTH = MAP_SIDE * MAP_SIDE;
    localparam int AW    = $clog2(DEPTH);

    logic          mem_reg [DEPTH];
    logic          rd_data_reg;
    logic          clr_busy_reg;
    logic [AW-1:0] clr_cnt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_cnt_reg  <= '0;
        end else if (clr_busy_reg) begin
            clr_cnt_reg <= clr_cnt_reg + AW'(1);
            if (clr_cnt_reg == AW'(DEPTH - 1)) begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (clr_busy_reg) begin
            mem_reg[clr_cnt_reg] <= 1'b0;
        end else if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;
    assign busy    = clr_busy_reg;

endmodule

/* design/grid_ray_caster_dda_unit.sv */
// ----------------------------------------------------------------------------
// Grid ray caster DDA unit
// Map write: stored when taken. Cast: camera, delta x and delta y divisions, a fourth
// for distance on a wall hit, then a step and a check state per cell walked (map read).
// One item at a time; a finished result waits in the output register.
// Reset: configuration and control registers take their defaults, then a sweep clears
// the map while no item is taken.
// ----------------------------------------------------------------------------
module grid_ray_caster_dda_unit #(
    parameter int MAP_SIDE = grcd_pkg::MAP_SIDE_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [grcd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [grcd_pkg::CFG_DAT_W-1:0] cfg_data,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_op,
    input  logic [grcd_pkg::CELL_W-1:0]    s_cell_x,
    input  logic [grcd_pkg::CELL_W-1:0]    s_cell_y,
    input  logic                           s_cell_is_wall,
    input  logic [grcd_pkg::COL_W-1:0]     s_column,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [grcd_pkg::COL_W-1:0]     m_ray_column,
    output logic [grcd_pkg::DIST_W-1:0]    m_wall_distance,
    output logic                           m_hit_side,
    output logic [grcd_pkg::CELL_W-1:0]    m_hit_cell_x,
    output logic [grcd_pkg::CELL_W-1:0]    m_hit_cell_y,
    output logic [grcd_pkg::POS_W-1:0]     m_hit_coord,
    output logic                           m_escaped
);
    import grcd_pkg::*;

    localparam int MAPW  = $clog2(MAP_SIDE);
    localparam int AW    = $clog2(MAP_SIDE * MAP_SIDE);
    localparam int CW    = ((MAPW > CELL_W) ? MAPW : CELL_W) + 2;
    localparam int NUMW  = ((MAPW + FRAC_BITS + 1) > POS_W) ? (MAPW + FRAC_BITS + 1) : POS_W;
    localparam int DVW   = NUMW + FRAC_BITS;
    localparam int DSW   = RAY_W - 1;
    localparam int LAST  = 2 * MAP_SIDE + 3;
    localparam int STW   = $clog2(LAST + 1);

    // configuration
    logic [POS_W-1:0]        pos_x_reg, pos_y_reg;
    logic signed [DIR_W-1:0] dir_x_reg, dir_y_reg, plane_x_reg, plane_y_reg;
    logic [SW_W-1:0]         screen_reg;

    // sequencer and datapath
    st_t                     state_reg, state_next;
    logic [COL_W-1:0]        col_reg;
    logic signed [CAM_W-1:0] cam_reg;
    logic signed [RAY_W-1:0] rx_reg, ry_reg;
    logic [DLT_W-1:0]        dx_reg, dy_reg;
    logic [SIDE_W-1:0]       sx_reg, sy_reg;
    logic signed [CW-1:0]    mx_reg, my_reg;
    logic                    side_reg;
    logic [STW-1:0]          step_reg;
    logic [DIST_W-1:0]       dist_reg;
    logic [POS_W-1:0]        coord_reg;
    logic                    esc_reg;
    logic signed [PROD_W-1:0] mul_p_reg;

    // output register
    logic                    m_valid_reg;
    logic [COL_W-1:0]        out_col_reg;
    logic [DIST_W-1:0]       out_dist_reg;
    logic                    out_side_reg;
    logic [CELL_W-1:0]       out_cx_reg, out_cy_reg;
    logic [POS_W-1:0]        out_coord_reg;
    logic                    out_esc_reg;

    // combinational
    logic                    s_fire, cast_fire, map_busy, map_rd;
    logic                    wr_en;
    logic [2*CW-1:0]         wr_addr_wide, rd_addr_wide;
    logic                    step_x, oob, out_load;
    logic signed [CW-1:0]    mx_step, my_step, mx_next, my_next;
    logic                    div_start, div_done;
    logic [DVW-1:0]          div_dividend, div_q;
    logic [DSW-1:0]          div_divisor;
    logic signed [MA_W-1:0]  mul_a;
    logic signed [MB_W-1:0]  mul_b;
    logic [FRAC1_W-1:0]      frac_x, frac_y;
    logic [DSW-1:0]          rx_mag, ry_mag;
    logic [MAPW:0]           edge_cell;
    logic signed [NUMW:0]    num;
    logic [NUMW-1:0]         num_mag;
    logic [POS_W-1:0]        hit_pos, other_pos;
    logic signed [PROD_W-1:0] coord_w;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE) && !map_busy;
    assign s_fire    = s_valid && s_ready;
    assign cast_fire = s_fire && (s_op == OP_CAST);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_x_reg   <= '0;
            pos_y_reg   <= '0;
            dir_x_reg   <= DIR_X_RST;
            dir_y_reg   <= DIR_Y_RST;
            plane_x_reg <= PLANE_X_RST;
            plane_y_reg <= PLANE_Y_RST;
            screen_reg  <= SCREEN_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_POS_X:   pos_x_reg   <= cfg_data;
                CFG_POS_Y:   pos_y_reg   <= cfg_data;
                CFG_DIR_X:   dir_x_reg   <= $signed(cfg_data[DIR_W-1:0]);
                CFG_DIR_Y:   dir_y_reg   <= $signed(cfg_data[DIR_W-1:0]);
                CFG_PLANE_X: plane_x_reg <= $signed(cfg_data[DIR_W-1:0]);
                CFG_PLANE_Y: plane_y_reg <= $signed(cfg_data[DIR_W-1:0]);
                CFG_SCREEN:  screen_reg  <= cfg_data[SW_W-1:0];
                default: ;
            endcase
        end
    end

    // map store
    assign wr_en = s_fire && (s_op == OP_WRITE)
                   && ({2'b00, s_cell_x} < 8'(MAP_SIDE) || MAP_SIDE > 64)
                   && ({2'b00, s_cell_y} < 8'(MAP_SIDE) || MAP_SIDE > 64);
    assign wr_addr_wide = (2*CW)'(s_cell_y) * (2*CW)'(MAP_SIDE) + (2*CW)'(s_cell_x);

    assign step_x  = sx_reg < sy_reg;
    assign mx_step = rx_reg[RAY_W-1] ? mx_reg - CW'(1) : mx_reg + CW'(1);
    assign my_step = ry_reg[RAY_W-1] ? my_reg - CW'(1) : my_reg + CW'(1);
    assign mx_next = step_x ? mx_step : mx_reg;
    assign my_next = step_x ? my_reg : my_step;
    assign rd_addr_wide = (2*CW)'($unsigned(my_next)) * (2*CW)'(MAP_SIDE)
                        + (2*CW)'($unsigned(mx_next));

    assign oob = mx_reg[CW-1] || my_reg[CW-1]
                 || ($unsigned(mx_reg) >= CW'(MAP_SIDE))
                 || ($unsigned(my_reg) >= CW'(MAP_SIDE));

    grcd_map #(.MAP_SIDE(MAP_SIDE)) u_map (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (wr_en),
        .wr_addr (wr_addr_wide[AW-1:0]),
        .wr_data (s_cell_is_wall),
        .rd_addr (rd_addr_wide[AW-1:0]),
        .rd_data (map_rd),
        .busy    (map_busy)
    );

    grcd_div #(.DVW(DVW), .DSW(DSW)) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_q)
    );

    // operand shaping
    assign rx_mag = rx_reg[RAY_W-1] ? DSW'(-rx_reg) : rx_reg[DSW-1:0];
    assign ry_mag = ry_reg[RAY_W-1] ? DSW'(-ry_reg) : ry_reg[DSW-1:0];
    assign frac_x = rx_reg[RAY_W-1] ? {1'b0, pos_x_reg[FRAC_BITS-1:0]}
                  : (FRAC1_W'(1) << FRAC_BITS) - {1'b0, pos_x_reg[FRAC_BITS-1:0]};
    assign frac_y = ry_reg[RAY_W-1] ? {1'b0, pos_y_reg[FRAC_BITS-1:0]}
                  : (FRAC1_W'(1) << FRAC_BITS) - {1'b0, pos_y_reg[FRAC_BITS-1:0]};

    assign hit_pos   = side_reg ? pos_y_reg : pos_x_reg;
    assign other_pos = side_reg ? pos_x_reg : pos_y_reg;
    assign edge_cell = side_reg
        ? {1'b0, my_reg[MAPW-1:0]} + (MAPW+1)'(ry_reg[RAY_W-1])
        : {1'b0, mx_reg[MAPW-1:0]} + (MAPW+1)'(rx_reg[RAY_W-1]);
    assign num     = $signed((NUMW+1)'({edge_cell, {FRAC_BITS{1'b0}}}))
                   - $signed((NUMW+1)'(hit_pos));
    assign num_mag = num[NUMW] ? NUMW'(-num) : num[NUMW-1:0];
    assign coord_w = $signed(PROD_W'(other_pos)) + (mul_p_reg >>> FRAC_BITS);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:      if (cast_fire) state_next = ST_CAM;
            ST_CAM:       if (div_done) state_next = ST_MUL_RX;
            ST_MUL_RX:    state_next = ST_MUL_RY;
            ST_MUL_RY:    state_next = ST_RY_CAP;
            ST_RY_CAP:    state_next = ST_DIV_DX;
            ST_DIV_DX:    if (div_done) state_next = ST_DIV_DY;
            ST_DIV_DY:    if (div_done) state_next = ST_SX_MUL;
            ST_SX_MUL:    state_next = ST_SY_MUL;
            ST_SY_MUL:    state_next = ST_SY_CAP;
            ST_SY_CAP:    state_next = ST_STEP;
            ST_STEP:      state_next = ST_CHECK;
            ST_CHECK: begin
                priority if (oob) state_next = ST_DONE;
                else if (map_rd) state_next = ST_DIST;
                else if (step_reg == STW'(LAST)) state_next = ST_DONE;
                else state_next = ST_STEP;
            end
            ST_DIST:      if (div_done) state_next = ST_COORD_MUL;
            ST_COORD_MUL: state_next = ST_COORD;
            ST_COORD:     state_next = ST_DONE;
            ST_DONE:      if (out_load) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // unit controls
    always_comb begin
        div_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = '0;
        mul_a        = '0;
        mul_b        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                div_start    = cast_fire;
                div_dividend = DVW'(s_column) << (FRAC_BITS + 1);
                div_divisor  = (screen_reg == '0) ? DSW'(1) : DSW'(screen_reg);
            end
            ST_RY_CAP: begin
                div_start    = 1'b1;
                div_dividend = DVW'(1) << (2 * FRAC_BITS);
                div_divisor  = rx_mag;
            end
            ST_DIV_DX: begin
                div_start    = div_done;
                div_dividend = DVW'(1) << (2 * FRAC_BITS);
                div_divisor  = ry_mag;
            end
            ST_CHECK: begin
                div_start    = !oob && map_rd;
                div_dividend = {num_mag, {FRAC_BITS{1'b0}}};
                div_divisor  = side_reg ? ry_mag : rx_mag;
            end
            ST_MUL_RX: begin
                mul_a = MA_W'(plane_x_reg);
                mul_b = cam_reg;
            end
            ST_MUL_RY: begin
                mul_a = MA_W'(plane_y_reg);
                mul_b = cam_reg;
            end
            ST_SX_MUL: begin
                mul_a = $signed(MA_W'(dx_reg[DLT_W-7:0]));
                mul_b = $signed(MB_W'(frac_x));
            end
            ST_SY_MUL: begin
                mul_a = $signed(MA_W'(dy_reg[DLT_W-7:0]));
                mul_b = $signed(MB_W'(frac_y));
            end
            ST_COORD_MUL: begin
                mul_a = side_reg ? MA_W'(rx_reg) : MA_W'(ry_reg);
                mul_b = $signed(MB_W'(dist_reg));
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        mul_p_reg <= mul_a * mul_b;
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                if (cast_fire) col_reg <= s_column;
            end
            ST_CAM: begin
                if (div_done) cam_reg <= $signed(CAM_W'(div_q) - (CAM_W'(1) << FRAC_BITS));
            end
            ST_MUL_RY: begin
                rx_reg <= RAY_W'(dir_x_reg) + RAY_W'(mul_p_reg >>> FRAC_BITS);
            end
            ST_RY_CAP: begin
                ry_reg <= RAY_W'(dir_y_reg) + RAY_W'(mul_p_reg >>> FRAC_BITS);
            end
            ST_DIV_DX: begin
                if (div_done) begin
                    dx_reg <= (rx_reg == '0 || div_q >= DVW'(DELTA_INF))
                              ? DLT_W'(DELTA_INF) : DLT_W'(div_q);
                end
            end
            ST_DIV_DY: begin
                if (div_done) begin
                    dy_reg <= (ry_reg == '0 || div_q >= DVW'(DELTA_INF))
                              ? DLT_W'(DELTA_INF) : DLT_W'(div_q);
                end
            end
            ST_SY_MUL: begin
                sx_reg <= (dx_reg == DLT_W'(DELTA_INF)) ? SIDE_W'(DELTA_INF)
                          : SIDE_W'(mul_p_reg >>> FRAC_BITS);
            end
            ST_SY_CAP: begin
                sy_reg   <= (dy_reg == DLT_W'(DELTA_INF)) ? SIDE_W'(DELTA_INF)
                            : SIDE_W'(mul_p_reg >>> FRAC_BITS);
                mx_reg   <= $signed(CW'(pos_x_reg[POS_W-1:FRAC_BITS]));
                my_reg   <= $signed(CW'(pos_y_reg[POS_W-1:FRAC_BITS]));
                step_reg <= '0;
                side_reg <= 1'b0;
            end
            ST_STEP: begin
                if (step_x) begin
                    sx_reg   <= sx_reg + SIDE_W'(dx_reg);
                    side_reg <= 1'b0;
                end else begin
                    sy_reg   <= sy_reg + SIDE_W'(dy_reg);
                    side_reg <= 1'b1;
                end
                mx_reg <= mx_next;
                my_reg <= my_next;
            end
            ST_CHECK: begin
                esc_reg  <= oob || !map_rd;
                step_reg <= step_reg + STW'(1);
            end
            ST_DIST: begin
                if (div_done) begin
                    dist_reg <= (div_q > DVW'(DIST_MAX)) ? DIST_MAX : div_q[DIST_W-1:0];
                end
            end
            ST_COORD: begin
                priority if (coord_w < 0) coord_reg <= '0;
                else if (coord_w > $signed(PROD_W'(COORD_MAX))) coord_reg <= COORD_MAX;
                else coord_reg <= coord_w[POS_W-1:0];
            end
            default: ;
        endcase
    end

    // output register
    assign out_load = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_col_reg   <= col_reg;
            out_esc_reg   <= esc_reg;
            out_dist_reg  <= esc_reg ? DIST_MAX : dist_reg;
            out_side_reg  <= esc_reg ? 1'b0 : side_reg;
            out_cx_reg    <= esc_reg ? '0 : mx_reg[CELL_W-1:0];
            out_cy_reg    <= esc_reg ? '0 : my_reg[CELL_W-1:0];
            out_coord_reg <= esc_reg ? '0 : coord_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_ray_column    = out_col_reg;
    assign m_wall_distance = out_dist_reg;
    assign m_hit_side      = out_side_reg;
    assign m_hit_cell_x    = out_cx_reg;
    assign m_hit_cell_y    = out_cy_reg;
    assign m_hit_coord     = out_coord_reg;
    assign m_escaped       = out_esc_reg;

endmodule

/* design/grcd_checker.sv */
// ----------------------------------------------------------------------------
// Grid ray caster port checker
// Watches the top-level ports of the ray caster over time.
// ----------------------------------------------------------------------------
`include "grid_ray_caster_dda_unit_assert.svh"

module grcd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        cfg_valid,
    input logic        cfg_ready,
    input logic [2:0]  cfg_index,
    input logic [21:0] cfg_data,
    input logic        s_valid,
    input logic        s_ready,
    input logic        s_op,
    input logic [5:0]  s_cell_x,
    input logic [5:0]  s_cell_y,
    input logic        s_cell_is_wall,
    input logic [11:0] s_column,
    input logic        m_valid,
    input logic        m_ready,
    input logic [11:0] m_ray_column,
    input logic [23:0] m_wall_distance,
    input logic        m_hit_side,
    input logic [5:0]  m_hit_cell_x,
    input logic [5:0]  m_hit_cell_y,
    input logic [21:0] m_hit_coord,
    input logic        m_escaped
);

    `GRCD_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_ray_column) && $stable(m_wall_distance))
    `GRCD_ASSERT_NOW(a_escape_fields, m_valid && m_escaped, (m_wall_distance == 24'hFFFFFF) && !m_hit_side && (m_hit_cell_x == 6'd0) && (m_hit_coord == 22'd0))
    `GRCD_ASSERT_NEXT(a_no_instant_result, s_valid && s_ready && !m_valid, !m_valid)
    `GRCD_ASSERT_NOW(a_reset_empty, $past(!aresetn), !m_valid)

endmodule

bind grid_ray_caster_dda_unit grcd_checker u_grcd_checker (.*);
